>>> rtl/core/pfcr_pkg.sv
// Package for the eight-line parallel feedback comb reverb.
// Holds the sizes, register codes, tap factors and the line control bundle.
// Depends on nothing; every module of the block imports it.
package pfcr_pkg;

    localparam int TAPS            = 8;
    localparam int SAMPLE_WIDTH    = 16;
    localparam int BASE_WIDTH      = 12;
    localparam int GAIN_WIDTH      = 16;
    localparam int LINE_DEPTH      = 8192;
    localparam int ADDR_WIDTH      = $clog2(LINE_DEPTH);
    localparam int FILL_WIDTH      = ADDR_WIDTH + 1;
    localparam int MAX_BASE_DELAY  = 2048;
    localparam int TENTH_WIDTH     = 6;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_INDEX_WIDTH = 1;

    // base * tenth stays at or below 2048 * 37 = 75776
    localparam int PROD_WIDTH  = 17;
    // divide by ten: multiply by ceil(2^19 / 10) and drop 19 bits,
    // exact for every product below 87381
    localparam int RECIP_WIDTH = 16;
    localparam int RECIP_SHIFT = 19;
    localparam int QUOT_WIDTH  = PROD_WIDTH + RECIP_WIDTH - RECIP_SHIFT;
    localparam logic [RECIP_WIDTH-1:0] RECIP_TENTH = 16'd52429;

    // shortest delay that never reads a row still in flight
    localparam int SAFE_DELAY = 3;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic [ADDR_WIDTH-1:0]          t_addr;
    typedef logic [FILL_WIDTH-1:0]          t_fill;
    typedef logic [BASE_WIDTH-1:0]          t_base;
    typedef logic [GAIN_WIDTH-1:0]          t_gain;
    typedef logic [TENTH_WIDTH-1:0]         t_tenth;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_BASE_DELAY    = 1'b0,
        REG_FEEDBACK_GAIN = 1'b1
    } t_cfg_reg;

    localparam t_base BASE_DELAY_RESET    = 12'd1323;
    localparam t_gain FEEDBACK_GAIN_RESET = 16'd32768;
    localparam t_base BASE_LIMIT          = t_base'(MAX_BASE_DELAY);

    // line delay factors in tenths of the base delay
    localparam t_tenth TENTHS [TAPS] = '{
        6'd10, 6'd13, 6'd17, 6'd21, 6'd23, 6'd27, 6'd31, 6'd37
    };

    // shared pipeline control and data handed to every line
    typedef struct packed {
        logic    adv;
        logic    wr_en;
        t_base   base;
        t_gain   gain;
        t_fill   fill;
        t_addr   rd_wp;
        t_addr   wr_wp;
        t_sample wr_sample;
    } t_line_ctl;

endpackage

>>> rtl/core/pfcr_line.sv
// One feedback delay line: delay length, line memory, feedback multiply
// and saturating write-back, spread over the shared pipeline stages.
// Depends on pfcr_pkg.
module pfcr_line import pfcr_pkg::*; (
    input  logic      i_clk,
    input  t_tenth    i_tenth,
    input  t_line_ctl i_ctl,
    output t_sample   o_delayed
);

    logic [BASE_WIDTH+TENTH_WIDTH-1:0]   n_prod_full;
    logic [PROD_WIDTH-1:0]               r_prod;
    logic [PROD_WIDTH+RECIP_WIDTH-1:0]   n_scaled;
    logic [QUOT_WIDTH-1:0]               r_delay;
    t_addr                               n_delay;
    t_addr                               n_rd_addr;
    t_sample                             r_mem [LINE_DEPTH];
    t_sample                             r_rd_data;
    logic                                r_rd_zero;
    logic signed [GAIN_WIDTH:0]          n_gain;
    logic signed [SAMPLE_WIDTH+GAIN_WIDTH:0] n_product;
    logic signed [SAMPLE_WIDTH:0]        r_fb;
    logic signed [SAMPLE_WIDTH+1:0]      n_wr_sum;
    t_sample                             n_wr_data;

    // stage 1: scale the base delay by this line's factor in tenths
    assign n_prod_full = i_ctl.base * i_tenth;

    // stage 2: divide by ten through the reciprocal
    assign n_scaled = r_prod * RECIP_TENTH;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_prod  <= n_prod_full[PROD_WIDTH-1:0];
            r_delay <= n_scaled[RECIP_SHIFT +: QUOT_WIDTH];
        end
    end

    // clamp to the line length and form the read address
    always_comb begin
        if (r_delay >= QUOT_WIDTH'(LINE_DEPTH)) begin
            n_delay = t_addr'(LINE_DEPTH - 1);
        end else begin
            n_delay = r_delay[ADDR_WIDTH-1:0];
        end
        n_rd_addr = i_ctl.rd_wp - n_delay;
    end

    // line memory: read on the stage 2 advance, write back from stage 4
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_wp] <= n_wr_data;
        end
        if (i_ctl.adv) begin
            r_rd_data <= r_mem[n_rd_addr];
            r_rd_zero <= {1'b0, n_rd_addr} >= i_ctl.fill;
        end
    end

    // stage 3: rows beyond the fill count were never written and read as zero
    assign o_delayed = r_rd_zero ? '0 : r_rd_data;
    assign n_gain    = {1'b0, i_ctl.gain};
    assign n_product = o_delayed * n_gain;

    // keep the product shifted down by the gain width (floor)
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_fb <= n_product[SAMPLE_WIDTH+GAIN_WIDTH:GAIN_WIDTH];
        end
    end

    // stage 4: add the input and saturate to the sample range
    always_comb begin
        n_wr_sum = (SAMPLE_WIDTH+2)'(i_ctl.wr_sample) + (SAMPLE_WIDTH+2)'(r_fb);
        if (n_wr_sum[SAMPLE_WIDTH+1:SAMPLE_WIDTH-1] == 3'b000 ||
            n_wr_sum[SAMPLE_WIDTH+1:SAMPLE_WIDTH-1] == 3'b111) begin
            n_wr_data = n_wr_sum[SAMPLE_WIDTH-1:0];
        end else if (n_wr_sum[SAMPLE_WIDTH+1]) begin
            n_wr_data = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end else begin
            n_wr_data = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    end

endmodule

>>> rtl/core/parallel_feedback_comb_reverb.sv
// Top level of the eight-line parallel feedback comb reverb.
// Holds the request handshakes, configuration, write position and output sum.
// Depends on pfcr_pkg and pfcr_line.
//
//   channel  direction  handshake                    payload
//   in       sink       i_in_valid / o_in_stall      i_sample_in
//   out      source     o_out_valid / i_out_stall    o_sample_out
//   cfg      sink       i_cfg_we                     i_cfg_index, i_cfg_data
//
// One request per cycle while neither an output stall nor the throttle below holds the input.
// Each line memory takes one read and one write per cycle; with a base delay
// below three a request waits until the four stages up to and including the
// write-back are empty, so it is not taken while an earlier request is in them.
// Reset is synchronous; the line memories are not swept, a fill count marks
// the rows written since reset and the rest read as zero.
// A stall on the output freezes every stage; nothing is dropped or repeated.
module parallel_feedback_comb_reverb import pfcr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  t_sample                    i_sample_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output t_sample                    o_sample_out,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data
);

    logic                          n_adv;
    logic                          n_accept;
    logic                          n_throttle;
    logic [4:0]                    r_valid;
    t_addr                         r_wp;
    t_addr                         r_wp_s1;
    t_addr                         r_wp_s2;
    t_addr                         r_wp_s3;
    t_addr                         r_wp_s4;
    t_sample                       r_x_s1;
    t_sample                       r_x_s2;
    t_sample                       r_x_s3;
    t_sample                       r_x_s4;
    t_fill                         r_fill;
    t_base                         r_base_delay;
    t_gain                         r_feedback_gain;
    t_base                         n_base;
    t_line_ctl                     n_line_ctl;
    t_sample                       n_delayed [TAPS];
    logic signed [SAMPLE_WIDTH:0]  r_pair [TAPS/2];
    logic signed [SAMPLE_WIDTH+1:0] r_quad [TAPS/4];
    logic signed [SAMPLE_WIDTH+2:0] n_total;
    logic                          r_out_valid;
    t_sample                       r_out_sample;

    // advance when the output register is free or being taken
    assign n_adv      = !r_out_valid || !i_out_stall;
    assign n_throttle = (r_base_delay < t_base'(SAFE_DELAY)) && (|r_valid[3:0]);
    assign o_in_stall = !n_adv || n_throttle;
    assign n_accept   = i_in_valid && !o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_delay    <= BASE_DELAY_RESET;
            r_feedback_gain <= FEEDBACK_GAIN_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_BASE_DELAY: begin
                    r_base_delay <= i_cfg_data[BASE_WIDTH-1:0];
                end
                REG_FEEDBACK_GAIN: begin
                    r_feedback_gain <= i_cfg_data[GAIN_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // control: valid bits, write position, fill count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (n_accept) begin
                r_wp <= r_wp + 1'b1;
            end
            if (n_adv) begin
                r_valid     <= {r_valid[3:0], n_accept};
                r_out_valid <= r_valid[4];
                if (r_valid[3] && r_fill != t_fill'(LINE_DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    // carry sample and write position alongside the valid bits
    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_wp_s1 <= r_wp;
            r_wp_s2 <= r_wp_s1;
            r_wp_s3 <= r_wp_s2;
            r_wp_s4 <= r_wp_s3;
            r_x_s1  <= i_sample_in;
            r_x_s2  <= r_x_s1;
            r_x_s3  <= r_x_s2;
            r_x_s4  <= r_x_s3;
        end
    end

    // bundle for the lines
    always_comb begin
        n_base = (r_base_delay > BASE_LIMIT) ? BASE_LIMIT : r_base_delay;
        n_line_ctl.adv       = n_adv;
        n_line_ctl.wr_en     = n_adv && r_valid[3];
        n_line_ctl.base      = n_base;
        n_line_ctl.gain      = r_feedback_gain;
        n_line_ctl.fill      = r_fill;
        n_line_ctl.rd_wp     = r_wp_s2;
        n_line_ctl.wr_wp     = r_wp_s4;
        n_line_ctl.wr_sample = r_x_s4;
    end

    for (genvar g = 0; g < TAPS; g++) begin : g_line
        pfcr_line u_line (
            .i_clk     (i_clk),
            .i_tenth   (TENTHS[g]),
            .i_ctl     (n_line_ctl),
            .o_delayed (n_delayed[g])
        );
    end

    // sum the delayed samples over a registered tree
    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            for (int j = 0; j < TAPS/2; j++) begin
                r_pair[j] <= (SAMPLE_WIDTH+1)'(n_delayed[2*j]) +
                             (SAMPLE_WIDTH+1)'(n_delayed[2*j+1]);
            end
            for (int j = 0; j < TAPS/4; j++) begin
                r_quad[j] <= (SAMPLE_WIDTH+2)'(r_pair[2*j]) +
                             (SAMPLE_WIDTH+2)'(r_pair[2*j+1]);
            end
        end
    end

    assign n_total = (SAMPLE_WIDTH+3)'(r_quad[0]) + (SAMPLE_WIDTH+3)'(r_quad[1]);

    // drop three bits for the average and hold the result
    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_out_sample <= n_total[SAMPLE_WIDTH+2:3];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= t_fill'(LINE_DEPTH))
        else $error("fill count beyond line depth");

    a_wp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_accept |=> r_wp == t_addr'($past(r_wp) + 1'b1))
        else $error("write position did not advance on request");

    a_fill_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill < t_fill'(LINE_DEPTH)) |->
        (r_wp == t_addr'(r_fill + t_fill'($countones(r_valid[3:0])))))
        else $error("fill count out of step with requests in flight");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_valid[4]))
        else $error("result without a request in the last stage");
`endif

endmodule
